// ===== rtl/tpt_pkg.sv =====
// tpt_pkg: shared widths, register indexes, reset values and the
// command/status structs between the touch pen tracker controller and datapath.
// No dependencies.
package tpt_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int PRESS_W    = 15;
	localparam int COUNT_W    = 4;
	localparam int PROD_W     = 2 * SAMPLE_W;
	localparam int DIV_STEPS  = PROD_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = PRESS_W;

	localparam logic [CFG_IDX_W-1:0] REG_REPORT_ENABLE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_POLLS  = 2'd2;

	localparam logic               RST_REPORT_ENABLE  = 1'b1;
	localparam logic [PRESS_W-1:0] RST_PRESSURE_LIMIT = 15'd15000;
	localparam logic [COUNT_W-1:0] RST_RELEASE_POLLS  = 4'd2;
	localparam logic [COUNT_W-1:0] COUNT_TOP          = 4'd15;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

	typedef struct packed {
		logic load;     // latch the poll transaction
		logic mul;      // register the product, clear the remainder
		logic div_step; // one restoring divide step
		logic commit;   // update pen state, load the result register
	} tpt_cmd_t;

	typedef struct packed {
		logic needs_div; // live poll inputs give a candidate sample
	} tpt_status_t;

endpackage

// ===== rtl/touch_pen_tracker.sv =====
// touch_pen_tracker: resistive touchscreen pen state and pressure tracking.
// Top level; instantiates tpt_ctrl and tpt_datapath, uses tpt_pkg.
//
//   channel  handshake                 payload
//   poll     poll_valid / poll_stall   pen_touching, sample_x/y/z1/z2
//   result   result_valid / result_stall report_*, poll_again, edge_irq_armed
//   config   cfg_we                    cfg_index, cfg_data
//
// A touching poll with a candidate sample runs one multiply, then 24 restoring
// divide steps on the one-bit-a-cycle divider, then one commit. Other polls go
// straight to commit. A finished result waits in the output register; the next
// poll is accepted meanwhile and holds in commit until it is taken. Reset is
// asynchronous, active low, and resets config, pen state and FSM registers.
module touch_pen_tracker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tpt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tpt_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             poll_valid,
	output logic                             poll_stall,
	input  logic                             pen_touching,
	input  logic [tpt_pkg::SAMPLE_W-1:0]     sample_x,
	input  logic [tpt_pkg::SAMPLE_W-1:0]     sample_y,
	input  logic [tpt_pkg::SAMPLE_W-1:0]     sample_z1,
	input  logic [tpt_pkg::SAMPLE_W-1:0]     sample_z2,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic                             report_valid,
	output logic [tpt_pkg::SAMPLE_W-1:0]     report_x,
	output logic [tpt_pkg::SAMPLE_W-1:0]     report_y,
	output logic [tpt_pkg::PRESS_W-1:0]      report_pressure,
	output logic                             report_touch,
	output logic                             poll_again,
	output logic                             edge_irq_armed
);
	import tpt_pkg::*;

	tpt_cmd_t    cmd;
	tpt_status_t status;

	tpt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.poll_valid   (poll_valid),
		.poll_stall   (poll_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	tpt_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.pen_touching    (pen_touching),
		.sample_x        (sample_x),
		.sample_y        (sample_y),
		.sample_z1       (sample_z1),
		.sample_z2       (sample_z2),
		.report_valid    (report_valid),
		.report_x        (report_x),
		.report_y        (report_y),
		.report_pressure (report_pressure),
		.report_touch    (report_touch),
		.poll_again      (poll_again),
		.edge_irq_armed  (edge_irq_armed)
	);

endmodule

// ===== rtl/tpt_ctrl.sv =====
// tpt_ctrl: sequencing state machine of the touch pen tracker.
// Depends on tpt_pkg. Drives commands to tpt_datapath and owns both handshakes.
module tpt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                poll_valid,
	output logic                poll_stall,
	output logic                result_valid,
	input  logic                result_stall,
	input  tpt_pkg::tpt_status_t status,
	output tpt_pkg::tpt_cmd_t    cmd
);
	import tpt_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_DONE} state_t;

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;
	logic                result_valid_q;
	logic                accept;
	logic                out_free;

	assign poll_stall   = (state_q != ST_IDLE);
	assign accept       = poll_valid && (state_q == ST_IDLE);
	assign out_free     = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.mul      = (state_q == ST_MUL);
		cmd.div_step = (state_q == ST_DIV);
		cmd.commit   = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			step_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= status.needs_div ? ST_MUL : ST_DONE;
					end
				end
				ST_MUL: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> poll_stall)
		else $error("poll accepted while busy");
	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_q == LAST_STEP) |=> (state_q == ST_DONE))
		else $error("divide did not finish after last step");
	a_skip_div: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !status.needs_div) |=> (state_q == ST_DONE))
		else $error("rejected sample did not go straight to done");
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (result_valid_q && state_q == ST_IDLE))
		else $error("commit did not present a result");

endmodule

// ===== rtl/tpt_datapath.sv =====
// tpt_datapath: config registers, poll latch, multiplier, restoring divider,
// pen state and result register. Depends on tpt_pkg; driven by tpt_ctrl.
module tpt_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tpt_pkg::tpt_cmd_t                   cmd,
	output tpt_pkg::tpt_status_t                status,
	input  logic                                cfg_we,
	input  logic [tpt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tpt_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                pen_touching,
	input  logic [tpt_pkg::SAMPLE_W-1:0]        sample_x,
	input  logic [tpt_pkg::SAMPLE_W-1:0]        sample_y,
	input  logic [tpt_pkg::SAMPLE_W-1:0]        sample_z1,
	input  logic [tpt_pkg::SAMPLE_W-1:0]        sample_z2,
	output logic                                report_valid,
	output logic [tpt_pkg::SAMPLE_W-1:0]        report_x,
	output logic [tpt_pkg::SAMPLE_W-1:0]        report_y,
	output logic [tpt_pkg::PRESS_W-1:0]         report_pressure,
	output logic                                report_touch,
	output logic                                poll_again,
	output logic                                edge_irq_armed
);
	import tpt_pkg::*;

	logic                report_enable_q;
	logic [PRESS_W-1:0]  pressure_limit_q;
	logic [COUNT_W-1:0]  release_polls_q;

	logic                touch_q;
	logic                ok_q;
	logic [SAMPLE_W-1:0] x_q, y_q, z1_q, z2_q;

	logic [SAMPLE_W-1:0] rem_q;
	logic [PROD_W-1:0]   quo_q;
	logic [SAMPLE_W:0]   trial;
	logic                fits;

	logic [COUNT_W-1:0]  pen_count_q;
	logic [SAMPLE_W-1:0] held_x_q, held_y_q;
	logic [PRESS_W-1:0]  held_pressure_q;

	logic [COUNT_W-1:0]  pen_next;
	logic [SAMPLE_W-1:0] hx_next, hy_next;
	logic [PRESS_W-1:0]  hp_next;
	logic                emit, again, armed, too_high;

	assign status.needs_div = pen_touching && (sample_x != '0) && (sample_y != '0)
		&& (sample_z1 != '0) && (sample_z2 >= sample_z1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_enable_q  <= RST_REPORT_ENABLE;
			pressure_limit_q <= RST_PRESSURE_LIMIT;
			release_polls_q  <= RST_RELEASE_POLLS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_REPORT_ENABLE:  report_enable_q  <= cfg_data[0];
				REG_PRESSURE_LIMIT: pressure_limit_q <= cfg_data;
				REG_RELEASE_POLLS:  release_polls_q  <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			touch_q <= pen_touching;
			ok_q    <= status.needs_div;
			x_q     <= sample_x;
			y_q     <= sample_y;
			z1_q    <= sample_z1;
			z2_q    <= sample_z2;
		end
	end

	// restoring divide, dividend shifts out of quo_q as quotient bits shift in
	assign trial = {rem_q, quo_q[PROD_W-1]};
	assign fits  = (trial >= {1'b0, z1_q});

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			quo_q <= PROD_W'(x_q) * PROD_W'(z2_q - z1_q);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= fits ? SAMPLE_W'(trial - {1'b0, z1_q}) : trial[SAMPLE_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	assign too_high = (quo_q[PROD_W-1:PRESS_W] != '0) || (quo_q[PRESS_W-1:0] >= pressure_limit_q);

	always_comb begin
		pen_next = pen_count_q;
		hx_next  = held_x_q;
		hy_next  = held_y_q;
		hp_next  = held_pressure_q;
		emit     = 1'b0;
		again    = 1'b0;
		armed    = 1'b0;
		if (touch_q) begin
			again = 1'b1;
			if (!ok_q || too_high) begin
				hp_next = '0;
			end else begin
				hx_next  = x_q;
				hy_next  = y_q;
				hp_next  = quo_q[PRESS_W-1:0];
				pen_next = COUNT_W'(1);
				emit     = report_enable_q;
			end
		end else if (pen_count_q != '0 && pen_count_q <= release_polls_q
				&& pen_count_q != COUNT_TOP) begin
			pen_next = pen_count_q + 1'b1;
			again    = 1'b1;
		end else begin
			if (pen_count_q != '0) begin
				hp_next = '0;
				emit    = report_enable_q;
			end
			armed    = 1'b1;
			pen_next = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_count_q     <= '0;
			held_x_q        <= '0;
			held_y_q        <= '0;
			held_pressure_q <= '0;
		end else if (cmd.commit) begin
			pen_count_q     <= pen_next;
			held_x_q        <= hx_next;
			held_y_q        <= hy_next;
			held_pressure_q <= hp_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			report_valid    <= emit;
			report_x        <= emit ? hx_next : '0;
			report_y        <= emit ? hy_next : '0;
			report_pressure <= emit ? hp_next : '0;
			report_touch    <= emit;
			poll_again      <= again;
			edge_irq_armed  <= armed;
		end
	end

endmodule
